// File: design/eg_pkg.sv
// Shared types and constants for the ElGamal encryption block.
package eg_pkg;
  localparam int OPERAND_BITS = 64;
  localparam int W = OPERAND_BITS;
  localparam int CNT_BITS = $clog2(W);
  localparam int FIELD_BITS = 64;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GENERATOR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PUBLIC_KEY = 2'd2;

  typedef struct packed {
    logic         valid;
    logic [W-1:0] message;
    logic [W-1:0] nonce;
  } eg_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED1, ST_RED2, ST_SQ, ST_MUL, ST_FIN, ST_OUT
  } eg_state_t;
endpackage

// File: design/eg_if.sv
// Item channel interfaces: input (message, nonce) and result (ciphertext pair).
interface eg_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message;
  logic [63:0] nonce;
  modport source (output valid, output message, output nonce, input ready);
  modport sink (input valid, input message, input nonce, output ready);
endinterface

interface eg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] ephemeral_part;
  logic [63:0] masked_part;
  modport source (output valid, output ephemeral_part, output masked_part, input ready);
  modport sink (input valid, input ephemeral_part, input masked_part, output ready);
endinterface

// File: design/eg_front.sv
// Front end: accepts items and holds them in a two-entry queue.
module eg_front
  import eg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  eg_in_if.sink    in_ch,
  output eg_job_t  job,
  input  logic     pop
);
  logic [W-1:0] msg_r [2];
  logic [W-1:0] non_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;
  logic         push;

  assign in_ch.ready = (count_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;

  assign job.valid   = (count_r != 2'd0);
  assign job.message = msg_r[rd_ptr_r];
  assign job.nonce   = non_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      msg_r[wr_ptr_r] <= in_ch.message[W-1:0];
      non_r[wr_ptr_r] <= in_ch.nonce[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: design/eg_mulmod.sv
// Shift-and-add modular multiplier, one multiplier bit per cycle.
module eg_mulmod
  import eg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] p,
  output logic         done,
  output logic [W-1:0] result
);
  logic [W-1:0]        acc_r, a_r, b_r, p_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [W:0]          dbl, sum;
  logic [W-1:0]        dbl_m, acc_nxt;

  // acc = 2*acc mod p, then + a mod p when the current bit is set
  always_comb begin
    dbl   = {1'b0, acc_r} + {1'b0, acc_r};
    dbl_m = (dbl >= {1'b0, p_r}) ? W'(dbl - {1'b0, p_r}) : dbl[W-1:0];
    sum   = {1'b0, dbl_m} + {1'b0, a_r};
    if (b_r[W-1])
      acc_nxt = (sum >= {1'b0, p_r}) ? W'(sum - {1'b0, p_r}) : sum[W-1:0];
    else
      acc_nxt = dbl_m;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      p_r   <= p;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;
endmodule

// File: design/eg_back.sv
// Back end: sequences two modular exponentiations and the final multiply by m, and drives the result register.
module eg_back
  import eg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  eg_job_t      job,
  output logic         pop,
  input  logic [W-1:0] p,
  input  logic [W-1:0] g,
  input  logic [W-1:0] h,
  eg_out_if.source     out_ch
);
  eg_state_t           state_r, state_nxt;
  logic                issued_r, issued_nxt;
  logic [CNT_BITS-1:0] bit_r, bit_nxt;
  logic [W-1:0]        m_r, r_r, mr_r, gb_r, hb_r, acc_a_r, acc_b_r, c1_r;
  logic [W-1:0]        m_nxt, r_nxt, mr_nxt, gb_nxt, hb_nxt, acc_a_nxt, acc_b_nxt, c1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [W-1:0]        ep_r, mp_r, ep_nxt, mp_nxt;
  logic                start;
  logic [W-1:0]        op_a0, op_b0, op_a1, op_b1, res_a, res_b;
  logic                done_a, done_b;
  logic [W-1:0]        one;
  logic                p_zero;

  assign one    = (p == W'(1)) ? '0 : W'(1);
  assign p_zero = (p == '0);

  eg_mulmod u_mul_a (
    .clk, .rst_n, .start, .a(op_a0), .b(op_b0), .p, .done(done_a), .result(res_a)
  );
  eg_mulmod u_mul_b (
    .clk, .rst_n, .start, .a(op_a1), .b(op_b1), .p, .done(done_b), .result(res_b)
  );

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    bit_nxt       = bit_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    mr_nxt        = mr_r;
    gb_nxt        = gb_r;
    hb_nxt        = hb_r;
    acc_a_nxt     = acc_a_r;
    acc_b_nxt     = acc_b_r;
    c1_nxt        = c1_r;
    ep_nxt        = ep_r;
    mp_nxt        = mp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop           = 1'b0;
    start         = 1'b0;
    op_a0 = acc_a_r; op_b0 = acc_a_r;
    op_a1 = acc_b_r; op_b1 = acc_b_r;

    unique case (state_r)
      ST_RED1: begin op_a0 = one; op_b0 = g; op_a1 = one; op_b1 = h; end
      ST_RED2: begin op_a0 = one; op_b0 = m_r; op_a1 = one; op_b1 = m_r; end
      ST_MUL:  begin op_b0 = gb_r; op_b1 = hb_r; end
      ST_FIN:  begin op_a1 = mr_r; op_b1 = acc_b_r; end
      default: ;
    endcase

    if (state_r != ST_IDLE && state_r != ST_OUT && !issued_r) begin
      start      = 1'b1;
      issued_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (job.valid) begin
          pop       = 1'b1;
          m_nxt     = job.message;
          r_nxt     = job.nonce;
          bit_nxt   = CNT_BITS'(W - 1);
          state_nxt = ST_RED1;
        end
      end
      ST_RED1: if (done_a) begin
        gb_nxt     = res_a;
        hb_nxt     = res_b;
        issued_nxt = 1'b0;
        state_nxt  = ST_RED2;
      end
      ST_RED2: if (done_a) begin
        mr_nxt     = res_a;
        acc_a_nxt  = one;
        acc_b_nxt  = one;
        issued_nxt = 1'b0;
        state_nxt  = ST_SQ;
      end
      ST_SQ, ST_MUL: if (done_a) begin
        acc_a_nxt  = res_a;
        acc_b_nxt  = res_b;
        issued_nxt = 1'b0;
        if (state_r == ST_SQ && r_r[W-1]) begin
          state_nxt = ST_MUL;
        end else if (bit_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          r_nxt     = {r_r[W-2:0], 1'b0};
          state_nxt = ST_SQ;
        end
      end
      ST_FIN: if (done_a) begin
        c1_nxt     = res_b;
        issued_nxt = 1'b0;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // wait for the result register to free up
        if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          ep_nxt        = p_zero ? '0 : acc_a_r;
          mp_nxt        = p_zero ? '0 : c1_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r   <= bit_nxt;
    m_r     <= m_nxt;
    r_r     <= r_nxt;
    mr_r    <= mr_nxt;
    gb_r    <= gb_nxt;
    hb_r    <= hb_nxt;
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    c1_r    <= c1_nxt;
    ep_r    <= ep_nxt;
    mp_r    <= mp_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ephemeral_part = FIELD_BITS'(ep_r);
  assign out_ch.masked_part    = FIELD_BITS'(mp_r);

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_a == done_b) else $error("multiplier lanes out of step");
  a_idle_not_issued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !issued_r) else $error("multiply pending in idle");
  a_done_only_issued: assert property (@(posedge clk) disable iff (!rst_n)
    done_a |-> issued_r) else $error("multiply finished without request");
  a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_RED1) else $error("pop did not start a job");
endmodule

// File: design/elgamal_encrypt.sv
// ElGamal encryption block: c0 = g^r mod p, c1 = m * h^r mod p.
//
// Channels: in_ch carries (message, nonce), out_ch carries
// (ephemeral_part, masked_part); an item moves when valid and ready are
// both high. cfg_we/cfg_index/cfg_wdata write modulus (0), generator (1)
// and public key (2); other indexes are ignored. Write only while idle.
//
// Arithmetic: two shift-and-add modular multipliers run in lockstep. An
// item needs two reduction products, OPERAND_BITS squarings, one
// multiply per set nonce bit and a final product.
// A two-item input queue keeps accepting while one item is in work, and
// the result register lets the next item start while a result waits.
//
// Reset: registers return to p=11, g=2, h=1; queue and result emptied.
// A stalled receiver holds the result; work stops only when the next
// result is done and the register is still full.
module elgamal_encrypt
  import eg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  eg_in_if.sink                   in_ch,
  eg_out_if.source                out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_wdata
);
  logic [FIELD_BITS-1:0] modulus_r, generator_r, public_key_r;
  eg_job_t               job;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= FIELD_BITS'(11);
      generator_r  <= FIELD_BITS'(2);
      public_key_r <= FIELD_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:    modulus_r    <= cfg_wdata;
        REG_GENERATOR:  generator_r  <= cfg_wdata;
        REG_PUBLIC_KEY: public_key_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  eg_front u_front (.clk, .rst_n, .in_ch, .job, .pop);

  eg_back u_back (
    .clk, .rst_n, .job, .pop,
    .p(modulus_r[W-1:0]), .g(generator_r[W-1:0]), .h(public_key_r[W-1:0]),
    .out_ch
  );
endmodule
